/* hw/rtl/pst_pkg.sv */
package pst_pkg;

    // coordinate format, signed Q16.8
    localparam int COORD_BITS = 24;
    // magnitude register, wide enough for an edge delta and the normalized range
    localparam int MAGW = (COORD_BITS + 1 > 31) ? COORD_BITS + 1 : 31;

    // last iteration indexes of the shared sequential units
    localparam logic [4:0] SQRT_LAST = 5'd30;
    localparam logic [4:0] DIV_LAST  = 5'd16;

    // configuration register indexes
    localparam logic [1:0] CFG_CLOSED = 2'd0;
    localparam logic [1:0] CFG_WIDTH  = 2'd1;
    localparam logic [1:0] CFG_OFFX   = 2'd2;
    localparam logic [1:0] CFG_OFFY   = 2'd3;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] point_x;
        logic signed [COORD_BITS-1:0] point_y;
        logic                         last_point;
    } t_in;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] vertex_x;
        logic signed [COORD_BITS-1:0] vertex_y;
        logic                         coverage;
        logic                         last_of_run;
    } t_out;

    // datapath operations
    typedef enum logic [3:0] {
        OP_NONE,
        OP_ACCEPT,
        OP_CHECK,
        OP_SETUP,
        OP_NORM,
        OP_SQA,
        OP_SQB,
        OP_SQRT,
        OP_DINIT_A,
        OP_DINIT_B,
        OP_DSTEP,
        OP_MUL,
        OP_NCALC,
        OP_EMIT,
        OP_FINISH
    } t_op;

    // extra offset of a corner beyond the half-width normal
    typedef enum logic [2:0] {
        EX_NONE,
        EX_FPOS,
        EX_FNEG,
        EX_TPOS,
        EX_TNEG
    } t_extra;

    typedef struct packed {
        logic   end2;
        logic   nneg;
        t_extra extra;
        logic   cov;
    } t_corner;

    typedef struct packed {
        t_op        op;
        logic       edge_b;
        logic [2:0] quad;
        logic [2:0] slot;
        logic       last_vtx;
    } t_cmd;

    typedef struct packed {
        logic seen;
        logic last;
        logic closed;
        logic width_zero;
        logic eq_prev;
        logic eq_first;
        logic norm_ok;
        logic out_free;
    } t_sts;

    // saturate a wide sum to the coordinate range
    function automatic logic signed [COORD_BITS-1:0] sat(
        input logic signed [COORD_BITS+2:0] v
    );
        logic signed [COORD_BITS-1:0] r;
        if (v[COORD_BITS+2:COORD_BITS-1] == {4{v[COORD_BITS+2]}}) begin
            r = v[COORD_BITS-1:0];
        end else if (v[COORD_BITS+2]) begin
            r = {1'b1, {(COORD_BITS-1){1'b0}}};
        end else begin
            r = {1'b0, {(COORD_BITS-1){1'b1}}};
        end
        return r;
    endfunction

    // corner of a vertex: quads split as abc, acd
    function automatic t_corner corner(input logic [2:0] quad, input logic [2:0] slot);
        logic [1:0] k;
        t_corner    c;
        unique case (slot)
            3'd0, 3'd3: k = 2'd0;
            3'd1:       k = 2'd1;
            3'd2, 3'd4: k = 2'd2;
            3'd5:       k = 2'd3;
            default:    k = 2'd0;
        endcase
        unique case ({quad, k})
            // body
            5'b000_00: c = '{1'b0, 1'b0, EX_NONE, 1'b1};
            5'b000_01: c = '{1'b1, 1'b0, EX_NONE, 1'b1};
            5'b000_10: c = '{1'b1, 1'b1, EX_NONE, 1'b1};
            5'b000_11: c = '{1'b0, 1'b1, EX_NONE, 1'b1};
            // positive side fringe
            5'b001_00: c = '{1'b0, 1'b0, EX_NONE, 1'b1};
            5'b001_01: c = '{1'b1, 1'b0, EX_NONE, 1'b1};
            5'b001_10: c = '{1'b1, 1'b0, EX_FPOS, 1'b0};
            5'b001_11: c = '{1'b0, 1'b0, EX_FPOS, 1'b0};
            // negative side fringe
            5'b010_00: c = '{1'b0, 1'b1, EX_NONE, 1'b1};
            5'b010_01: c = '{1'b0, 1'b1, EX_FNEG, 1'b0};
            5'b010_10: c = '{1'b1, 1'b1, EX_FNEG, 1'b0};
            5'b010_11: c = '{1'b1, 1'b1, EX_NONE, 1'b1};
            // start cap
            5'b011_00: c = '{1'b0, 1'b1, EX_NONE, 1'b1};
            5'b011_01: c = '{1'b0, 1'b0, EX_NONE, 1'b1};
            5'b011_10: c = '{1'b0, 1'b0, EX_TNEG, 1'b0};
            5'b011_11: c = '{1'b0, 1'b1, EX_TNEG, 1'b0};
            // end cap
            5'b100_00: c = '{1'b1, 1'b0, EX_NONE, 1'b1};
            5'b100_01: c = '{1'b1, 1'b1, EX_NONE, 1'b1};
            5'b100_10: c = '{1'b1, 1'b1, EX_TPOS, 1'b0};
            5'b100_11: c = '{1'b1, 1'b0, EX_TPOS, 1'b0};
            default:   c = '{1'b0, 1'b0, EX_NONE, 1'b1};
        endcase
        return c;
    endfunction

endpackage

/* hw/rtl/pst_ctrl.sv */
module pst_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  pst_pkg::t_sts i_sts,
    output pst_pkg::t_cmd o_cmd
);
    import pst_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,
        S_SETUP,
        S_NORM,
        S_SQA,
        S_SQB,
        S_SQRT,
        S_DINA,
        S_DIVA,
        S_DINB,
        S_DIVB,
        S_MUL,
        S_NCALC,
        S_EMIT,
        S_FINISH
    } t_state;

    t_state     r_state, n_state;
    logic [4:0] r_cnt, n_cnt;
    logic [2:0] r_quad, n_quad;
    logic [2:0] r_slot, n_slot;
    logic       r_edge_b, n_edge_b;
    logic       r_do_b, n_do_b;
    logic       do_a, do_b, edge_end;

    // edge decisions and end of the vertex run
    assign do_a = i_sts.seen && !i_sts.width_zero && !i_sts.eq_prev;
    assign do_b = i_sts.seen && i_sts.last && i_sts.closed && !i_sts.width_zero
                  && !i_sts.eq_first;
    assign edge_end = (r_quad == 3'd4) && (r_slot == 3'd5);

    // next state and commands
    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        n_quad     = r_quad;
        n_slot     = r_slot;
        n_edge_b   = r_edge_b;
        n_do_b     = r_do_b;
        o_in_ready = 1'b0;
        o_cmd      = '{OP_NONE, r_edge_b, r_quad, r_slot, 1'b0};
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.op = OP_ACCEPT;
                    n_state  = S_CHECK;
                end
            end
            S_CHECK: begin
                o_cmd.op = OP_CHECK;
                n_do_b   = do_b;
                if (do_a) begin
                    n_edge_b = 1'b0;
                    n_state  = S_SETUP;
                end else if (do_b) begin
                    n_edge_b = 1'b1;
                    n_state  = S_SETUP;
                end else begin
                    n_state = S_FINISH;
                end
            end
            S_SETUP: begin
                o_cmd.op = OP_SETUP;
                n_state  = S_NORM;
            end
            S_NORM: begin
                if (i_sts.norm_ok) begin
                    n_state = S_SQA;
                end else begin
                    o_cmd.op = OP_NORM;
                end
            end
            S_SQA: begin
                o_cmd.op = OP_SQA;
                n_state  = S_SQB;
            end
            S_SQB: begin
                o_cmd.op = OP_SQB;
                n_cnt    = '0;
                n_state  = S_SQRT;
            end
            S_SQRT: begin
                o_cmd.op = OP_SQRT;
                n_cnt    = r_cnt + 5'd1;
                if (r_cnt == SQRT_LAST) begin
                    n_state = S_DINA;
                end
            end
            S_DINA: begin
                o_cmd.op = OP_DINIT_A;
                n_cnt    = '0;
                n_state  = S_DIVA;
            end
            S_DIVA: begin
                o_cmd.op = OP_DSTEP;
                n_cnt    = r_cnt + 5'd1;
                if (r_cnt == DIV_LAST) begin
                    n_state = S_DINB;
                end
            end
            S_DINB: begin
                o_cmd.op = OP_DINIT_B;
                n_cnt    = '0;
                n_state  = S_DIVB;
            end
            S_DIVB: begin
                o_cmd.op = OP_DSTEP;
                n_cnt    = r_cnt + 5'd1;
                if (r_cnt == DIV_LAST) begin
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                o_cmd.op = OP_MUL;
                n_state  = S_NCALC;
            end
            S_NCALC: begin
                o_cmd.op = OP_NCALC;
                n_quad   = '0;
                n_slot   = '0;
                n_state  = S_EMIT;
            end
            S_EMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.op       = OP_EMIT;
                    o_cmd.last_vtx = edge_end && (r_edge_b || !r_do_b);
                    if (r_slot == 3'd5) begin
                        n_slot = '0;
                        n_quad = r_quad + 3'd1;
                    end else begin
                        n_slot = r_slot + 3'd1;
                    end
                    if (edge_end) begin
                        if (!r_edge_b && r_do_b) begin
                            n_edge_b = 1'b1;
                            n_state  = S_SETUP;
                        end else begin
                            n_state = S_FINISH;
                        end
                    end
                end
            end
            S_FINISH: begin
                o_cmd.op = OP_FINISH;
                n_state  = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // state and counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cnt    <= '0;
            r_quad   <= '0;
            r_slot   <= '0;
            r_edge_b <= 1'b0;
            r_do_b   <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cnt    <= n_cnt;
            r_quad   <= n_quad;
            r_slot   <= n_slot;
            r_edge_b <= n_edge_b;
            r_do_b   <= n_do_b;
        end
    end

endmodule

/* hw/rtl/pst_dp.sv */
module pst_dp (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [1:0]                       i_cfg_idx,
    input  logic [pst_pkg::COORD_BITS-1:0]   i_cfg_wdata,
    input  pst_pkg::t_in                     i_in,
    input  pst_pkg::t_cmd                    i_cmd,
    output pst_pkg::t_sts                    o_sts,
    output pst_pkg::t_out                    o_out,
    output logic                             o_out_valid,
    input  logic                             i_out_ready
);
    import pst_pkg::*;

    localparam int CW = COORD_BITS;

    // configuration
    logic                 r_closed;
    logic [15:0]          r_width;
    logic signed [CW-1:0] r_off_x, r_off_y;

    // polyline state
    logic signed [CW-1:0] r_first_x, r_first_y, r_prev_x, r_prev_y;
    logic                 r_seen;
    logic signed [CW-1:0] r_px, r_py;
    logic                 r_last;

    // edge arithmetic
    logic            r_dxneg, r_dyneg;
    logic [MAGW-1:0] r_a, r_b;
    logic [59:0]     r_sqa;
    logic [61:0]     r_v, r_res, r_bit;
    logic [46:0]     r_rem, r_dvs;
    logic [16:0]     r_q, r_ux;
    logic [32:0]     r_pnx, r_pny;
    logic signed [17:0] r_nx, r_ny;
    logic signed [10:0] r_fx, r_fy;

    // output register
    t_out r_out;
    logic r_out_valid;

    logic signed [CW-1:0] x1, y1, x2, y2, tr_x, tr_y;
    logic signed [CW:0]   dx, dy;
    logic [CW:0]          dx_mag, dy_mag;
    logic [MAGW-1:0]      m;
    logic                 m_hi;
    logic [61:0]          sq_trial;
    logic [30:0]          len;
    logic [32:0]          rn_x, rn_y;
    logic [17:0]          rf_x, rf_y;
    t_corner              c;
    logic signed [CW-1:0] bx, by;
    logic signed [17:0]   vnx, vny;
    logic signed [10:0]   ex, ey;
    logic signed [CW+2:0] sum_x, sum_y;

    // translated input point
    assign tr_x = sat((CW+3)'(i_in.point_x) + (CW+3)'(r_off_x));
    assign tr_y = sat((CW+3)'(i_in.point_y) + (CW+3)'(r_off_y));

    // edge endpoints
    assign x1 = i_cmd.edge_b ? r_px : r_prev_x;
    assign y1 = i_cmd.edge_b ? r_py : r_prev_y;
    assign x2 = i_cmd.edge_b ? r_first_x : r_px;
    assign y2 = i_cmd.edge_b ? r_first_y : r_py;

    assign dx     = (CW+1)'(x2) - (CW+1)'(x1);
    assign dy     = (CW+1)'(y2) - (CW+1)'(y1);
    assign dx_mag = dx[CW] ? (CW+1)'(-dx) : (CW+1)'(dx);
    assign dy_mag = dy[CW] ? (CW+1)'(-dy) : (CW+1)'(dy);

    // normalization window check
    assign m    = (r_a > r_b) ? r_a : r_b;
    assign m_hi = |m[MAGW-1:30];

    assign sq_trial = r_res + r_bit;
    assign len      = r_res[30:0];

    // rounded normal and unit magnitudes
    assign rn_x = r_pnx + 33'd65536;
    assign rn_y = r_pny + 33'd65536;
    assign rf_x = {1'b0, r_q} + 18'd128;
    assign rf_y = {1'b0, r_ux} + 18'd128;

    // vertex assembly
    assign c   = corner(i_cmd.quad, i_cmd.slot);
    assign bx  = c.end2 ? x2 : x1;
    assign by  = c.end2 ? y2 : y1;
    assign vnx = c.nneg ? -r_nx : r_nx;
    assign vny = c.nneg ? -r_ny : r_ny;

    always_comb begin
        unique case (c.extra)
            EX_FPOS: begin ex = r_fx;  ey = r_fy;  end
            EX_FNEG: begin ex = -r_fx; ey = -r_fy; end
            EX_TPOS: begin ex = r_fy;  ey = -r_fx; end
            EX_TNEG: begin ex = -r_fy; ey = r_fx;  end
            default: begin ex = '0;    ey = '0;    end
        endcase
    end

    assign sum_x = (CW+3)'(bx) + (CW+3)'(vnx) + (CW+3)'(ex);
    assign sum_y = (CW+3)'(by) + (CW+3)'(vny) + (CW+3)'(ey);

    // status to the controller
    assign o_sts.seen       = r_seen;
    assign o_sts.last       = r_last;
    assign o_sts.closed     = r_closed;
    assign o_sts.width_zero = (r_width == 16'd0);
    assign o_sts.eq_prev    = (r_px == r_prev_x) && (r_py == r_prev_y);
    assign o_sts.eq_first   = (r_px == r_first_x) && (r_py == r_first_y);
    assign o_sts.norm_ok    = !m_hi && m[29];
    assign o_sts.out_free   = !r_out_valid || i_out_ready;

    assign o_out       = r_out;
    assign o_out_valid = r_out_valid;

    // configuration, polyline state and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_closed    <= 1'b0;
            r_width     <= 16'd256;
            r_off_x     <= '0;
            r_off_y     <= '0;
            r_first_x   <= '0;
            r_first_y   <= '0;
            r_prev_x    <= '0;
            r_prev_y    <= '0;
            r_seen      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_CLOSED: r_closed <= i_cfg_wdata[0];
                    CFG_WIDTH:  r_width  <= i_cfg_wdata[15:0];
                    CFG_OFFX:   r_off_x  <= i_cfg_wdata;
                    CFG_OFFY:   r_off_y  <= i_cfg_wdata;
                    default:    r_closed <= r_closed;
                endcase
            end
            if (i_cmd.op == OP_CHECK) begin
                if (!r_seen) begin
                    r_first_x <= r_px;
                    r_first_y <= r_py;
                end
                r_seen <= !r_last;
            end
            if (i_cmd.op == OP_FINISH) begin
                r_prev_x <= r_px;
                r_prev_y <= r_py;
            end
            if (i_cmd.op == OP_EMIT) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        unique case (i_cmd.op)
            OP_ACCEPT: begin
                r_px   <= tr_x;
                r_py   <= tr_y;
                r_last <= i_in.last_point;
            end
            OP_SETUP: begin
                r_a     <= MAGW'(dx_mag);
                r_b     <= MAGW'(dy_mag);
                r_dxneg <= dx[CW];
                r_dyneg <= dy[CW];
            end
            OP_NORM: begin
                if (m_hi) begin
                    r_a <= r_a >> 1;
                    r_b <= r_b >> 1;
                end else begin
                    r_a <= r_a << 1;
                    r_b <= r_b << 1;
                end
            end
            OP_SQA: r_sqa <= r_a[29:0] * r_a[29:0];
            OP_SQB: begin
                r_v   <= {2'b00, r_sqa} + {2'b00, 60'(r_b[29:0] * r_b[29:0])};
                r_res <= '0;
                r_bit <= 62'(1) << 60;
            end
            OP_SQRT: begin
                if (r_v >= sq_trial) begin
                    r_v   <= r_v - sq_trial;
                    r_res <= (r_res >> 1) + r_bit;
                end else begin
                    r_res <= r_res >> 1;
                end
                r_bit <= r_bit >> 2;
            end
            OP_DINIT_A: begin
                r_rem <= {1'b0, r_a[29:0], 16'd0} + 47'(len >> 1);
                r_dvs <= {len, 16'd0};
                r_q   <= '0;
            end
            OP_DINIT_B: begin
                r_ux  <= r_q;
                r_rem <= {1'b0, r_b[29:0], 16'd0} + 47'(len >> 1);
                r_dvs <= {len, 16'd0};
                r_q   <= '0;
            end
            OP_DSTEP: begin
                if (r_rem >= r_dvs) begin
                    r_rem <= r_rem - r_dvs;
                    r_q   <= {r_q[15:0], 1'b1};
                end else begin
                    r_q   <= {r_q[15:0], 1'b0};
                end
                r_dvs <= r_dvs >> 1;
            end
            OP_MUL: begin
                r_pnx <= r_q * r_width;
                r_pny <= r_ux * r_width;
            end
            OP_NCALC: begin
                r_nx <= r_dyneg ? 18'(rn_x[32:17]) : -18'(rn_x[32:17]);
                r_ny <= r_dxneg ? -18'(rn_y[32:17]) : 18'(rn_y[32:17]);
                r_fx <= r_dyneg ? 11'(rf_x[17:8]) : -11'(rf_x[17:8]);
                r_fy <= r_dxneg ? -11'(rf_y[17:8]) : 11'(rf_y[17:8]);
            end
            OP_EMIT: begin
                r_out.vertex_x    <= sat(sum_x);
                r_out.vertex_y    <= sat(sum_y);
                r_out.coverage    <= c.cov;
                r_out.last_of_run <= i_cmd.last_vtx;
            end
            default: r_last <= r_last;
        endcase
    end

endmodule

/* hw/rtl/polyline_stroke_tessellator.sv */
// per edge: setup, normalize, 31 square-root steps, two 17-step divides, multiply, then
// 30 vertex beats, one per cycle while the output is taken; a point is accepted, checked
// and finished, with this work for each edge it emits (none, one or two)
// the single shared normalize/sqrt/divide datapath sets the rate; one point at a time
// reset: synchronous active low; clears first, previous and seen state, restores register defaults
module polyline_stroke_tessellator (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [1:0]                     i_cfg_idx,
    input  logic [pst_pkg::COORD_BITS-1:0] i_cfg_wdata,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  pst_pkg::t_in                   i_in,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output pst_pkg::t_out                  o_out
);
    import pst_pkg::*;

    t_cmd cmd;
    t_sts sts;

    // sequencer
    pst_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // arithmetic and vertex output
    pst_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in        (i_in),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_out       (o_out),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready)
    );

endmodule
